// ----- sv/iqws_pkg.sv -----
// Shared types and constants for the issue queue with wakeup and select.
package iqws_pkg;

  localparam int unsigned QUEUE_ENTRIES = 16;
  localparam int unsigned TAG_BITS = 5;
  localparam int unsigned ROB_BITS = 5;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned OUT_BITS = 32;
  localparam int unsigned IDX_BITS = $clog2(QUEUE_ENTRIES);

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INT = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam logic CLASS_INT = 1'b0;
  localparam logic CLASS_MUL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [ROB_BITS-1:0] rob;
    logic [TAG_BITS-1:0] a_tag;
    logic a_ok;
    logic [VALUE_BITS-1:0] a_val;
    logic [TAG_BITS-1:0] b_tag;
    logic b_ok;
    logic [VALUE_BITS-1:0] b_val;
    logic w_valid;
    logic [TAG_BITS-1:0] w_tag;
    logic [VALUE_BITS-1:0] w_val;
    logic [1:0] units;
  } item_t;

  typedef struct packed {
    logic int_issue;
    logic [ROB_BITS-1:0] int_rob;
    logic [OUT_BITS-1:0] int_first;
    logic [OUT_BITS-1:0] int_second;
    logic mul_issue;
    logic [ROB_BITS-1:0] mul_rob;
    logic [OUT_BITS-1:0] mul_first;
    logic [OUT_BITS-1:0] mul_second;
    logic rejected;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

endpackage

// ----- sv/iqws_ctrl.sv -----
// Controller: sequences load, one queue step, and result beat.
module iqws_ctrl import iqws_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        cmd.step = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/iqws_datapath.sv -----
// Datapath: entry storage, age matrix, select, wakeup and insert.
module iqws_datapath import iqws_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  item_t item_in,
  output result_t result
);

  localparam int unsigned N = QUEUE_ENTRIES;

  item_t it;
  logic [N-1:0] busy;
  logic [N-1:0] cls;
  logic [ROB_BITS-1:0] rob [N];
  logic [TAG_BITS-1:0] a_tag [N];
  logic [TAG_BITS-1:0] b_tag [N];
  logic [N-1:0] a_ok;
  logic [N-1:0] b_ok;
  logic [VALUE_BITS-1:0] a_val [N];
  logic [VALUE_BITS-1:0] b_val [N];
  logic [N-1:0] older [N];

  logic [N-1:0] cand_i, cand_m, pick_i, pick_m, busy_sel;
  logic [N-1:0] busy_next;
  logic [N-1:0] older_next [N];
  logic [IDX_BITS-1:0] slot;
  logic slot_found;
  logic dispatch;
  logic ins_en;
  logic ins_a_ok, ins_b_ok;
  logic [VALUE_BITS-1:0] ins_a_val, ins_b_val;
  result_t res;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cand_i[i] = busy[i] && cls[i] == CLASS_INT && a_ok[i] && b_ok[i] && it.units[0];
      cand_m[i] = busy[i] && cls[i] == CLASS_MUL && a_ok[i] && b_ok[i] && it.units[1];
    end
    for (int i = 0; i < N; i++) begin
      pick_i[i] = cand_i[i] && ((older[i] & cand_i) == '0);
      pick_m[i] = cand_m[i] && ((older[i] & cand_m) == '0);
    end
    busy_sel = busy & ~pick_i & ~pick_m;
    res = '0;
    for (int i = 0; i < N; i++) begin
      if (pick_i[i]) begin
        res.int_issue = 1'b1;
        res.int_rob = rob[i];
        res.int_first = OUT_BITS'(a_val[i]);
        res.int_second = OUT_BITS'(b_val[i]);
      end
      if (pick_m[i]) begin
        res.mul_issue = 1'b1;
        res.mul_rob = rob[i];
        res.mul_first = OUT_BITS'(a_val[i]);
        res.mul_second = OUT_BITS'(b_val[i]);
      end
    end
    slot = '0;
    slot_found = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!busy_sel[i]) begin
        slot = IDX_BITS'(i);
        slot_found = 1'b1;
      end
    end
    dispatch = it.kind == KIND_INT || it.kind == KIND_MUL;
    ins_en = dispatch && slot_found;
    res.rejected = dispatch && !slot_found;
    ins_a_ok = it.a_ok;
    ins_a_val = it.a_val;
    if (!it.a_ok && it.w_valid && it.w_tag == it.a_tag) begin
      ins_a_ok = 1'b1;
      ins_a_val = it.w_val;
    end
    ins_b_ok = it.b_ok;
    ins_b_val = it.b_val;
    if (!it.b_ok && it.w_valid && it.w_tag == it.b_tag) begin
      ins_b_ok = 1'b1;
      ins_b_val = it.w_val;
    end
    busy_next = busy_sel;
    for (int i = 0; i < N; i++) begin
      older_next[i] = older[i];
    end
    if (ins_en) begin
      busy_next[slot] = 1'b1;
      for (int i = 0; i < N; i++) begin
        older_next[i][slot] = 1'b0;
      end
      older_next[slot] = busy_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it <= item_in;
    end
    if (cmd.step) begin
      result <= res;
      for (int i = 0; i < N; i++) begin
        if (ins_en && slot == IDX_BITS'(i)) begin
          cls[i] <= (it.kind == KIND_MUL) ? CLASS_MUL : CLASS_INT;
          rob[i] <= it.rob;
          a_tag[i] <= it.a_tag;
          b_tag[i] <= it.b_tag;
          a_ok[i] <= ins_a_ok;
          b_ok[i] <= ins_b_ok;
          a_val[i] <= ins_a_val;
          b_val[i] <= ins_b_val;
        end else if (busy_sel[i] && it.w_valid) begin
          if (!a_ok[i] && a_tag[i] == it.w_tag) begin
            a_ok[i] <= 1'b1;
            a_val[i] <= it.w_val;
          end
          if (!b_ok[i] && b_tag[i] == it.w_tag) begin
            b_ok[i] <= 1'b1;
            b_val[i] <= it.w_val;
          end
        end
      end
    end
    if (rst) begin
      busy <= '0;
      for (int i = 0; i < N; i++) begin
        older[i] <= '0;
      end
    end else if (cmd.step) begin
      busy <= busy_next;
      for (int i = 0; i < N; i++) begin
        older[i] <= older_next[i];
      end
    end
  end

endmodule

// ----- sv/issue_queue_wakeup_select.sv -----
// Top level of the issue queue with operand capture and oldest-first select.
// Usage:
//   s_axis carries one step per beat: an optional dispatch, an optional
//   result broadcast and the free-unit mask. m_axis returns one beat per
//   step with the integer and multiply issue and the dispatch reject flag.
//   Within a step, select runs first, then wakeup, then insert, so a freed
//   entry can be reused and a same-step broadcast bypasses into a new entry.
// Timing:
//   A beat is taken in the idle state, the queue step runs in the next cycle,
//   and the result is shown from the send state that follows. One step is in
//   flight at a time, in the controller's load, step and send sequence; a
//   new beat is taken only after the result is accepted.
// Reset:
//   rst clears busy bits and the age matrix; entry payload is left as is.
// Stall:
//   While m_axis_tready is low the result holds and no new beat is taken.
module issue_queue_wakeup_select import iqws_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // dispatch_rob, first_tag, first_ready, first_value, second_tag,
  // second_ready, second_value, wake_tag, wake_value (118 bits, padded to 120)
  input  logic [119:0] s_axis_tdata,
  // dispatch_kind, wake_valid, units_free
  input  logic [4:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // int_rob, int_first, int_second, mul_rob, mul_first, mul_second,
  // dispatch_rejected (139 bits, padded to 144)
  output logic [143:0] m_axis_tdata,
  // int_issue, mul_issue
  output logic [1:0] m_axis_tuser
);

  cmd_t cmd;
  item_t item;
  result_t res;

  always_comb begin
    item.kind = s_axis_tuser[1:0];
    item.w_valid = s_axis_tuser[2];
    item.units = s_axis_tuser[4:3];
    item.rob = s_axis_tdata[4:0];
    item.a_tag = s_axis_tdata[9:5];
    item.a_ok = s_axis_tdata[10];
    item.a_val = s_axis_tdata[42:11];
    item.b_tag = s_axis_tdata[47:43];
    item.b_ok = s_axis_tdata[48];
    item.b_val = s_axis_tdata[80:49];
    item.w_tag = s_axis_tdata[85:81];
    item.w_val = s_axis_tdata[117:86];
  end

  iqws_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .cmd(cmd)
  );

  iqws_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .item_in(item),
    .result(res)
  );

  assign m_axis_tdata = {5'd0, res.rejected, res.mul_second, res.mul_first, res.mul_rob,
                         res.int_second, res.int_first, res.int_rob};
  assign m_axis_tuser = {res.mul_issue, res.int_issue};

endmodule

// ----- sv/iqws_checker.sv -----
// Port-level checker for the issue queue, bound to the top level.
module iqws_checker import iqws_pkg::*; (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [4:0] s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid) else $error("result late");

  a_reject_kind: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == KIND_NONE ||
    s_axis_tuser[1:0] == KIND_UNKNOWN) |=> ##1 !m_axis_tdata[138]) else $error("bad reject");

  a_unit_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[3] |=> ##1 !m_axis_tuser[0])
    else $error("issue to busy unit");

endmodule

bind issue_queue_wakeup_select iqws_checker u_chk (.*);

// ----- sim/issue_queue_wakeup_select_tb.sv -----
// Testbench for the issue queue: random and directed steps checked against a local queue model.
`timescale 1ns / 100ps

module issue_queue_wakeup_select_tb;
  import iqws_pkg::*;

  localparam int LIMIT = 200000;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic [4:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  issue_queue_wakeup_select DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  item_t pending_steps[$];
  result_t issue_expected[$];

  logic q_busy[QUEUE_ENTRIES];
  logic q_class[QUEUE_ENTRIES];
  logic [4:0] q_rob[QUEUE_ENTRIES];
  logic [4:0] q_atag[QUEUE_ENTRIES];
  logic q_aok[QUEUE_ENTRIES];
  logic [31:0] q_aval[QUEUE_ENTRIES];
  logic [4:0] q_btag[QUEUE_ENTRIES];
  logic q_bok[QUEUE_ENTRIES];
  logic [31:0] q_bval[QUEUE_ENTRIES];
  logic [QUEUE_ENTRIES-1:0] q_older[QUEUE_ENTRIES];

  int errors = 0;
  int cycles = 0;
  int steps_sent = 0;
  int issued_count = 0;
  int reject_count = 0;
  int send_idle_pct = 28;
  int recv_idle_pct = 72;
  logic hold_for_drain = 0;
  logic stim_done = 0;

  function automatic void pick_oldest(input logic cls, input logic free, output logic iss,
                                      output logic [4:0] rob, output logic [31:0] fa,
                                      output logic [31:0] fb);
    logic [QUEUE_ENTRIES-1:0] cand;
    cand = '0;
    iss = 0; rob = '0; fa = '0; fb = '0;
    if (free) begin
      for (int i = 0; i < QUEUE_ENTRIES; i++)
        cand[i] = q_busy[i] && q_class[i] == cls && q_aok[i] && q_bok[i];
      for (int i = 0; i < QUEUE_ENTRIES; i++) begin
        if (!iss && cand[i] && (q_older[i] & cand) == '0) begin
          q_busy[i] = 0;
          iss = 1; rob = q_rob[i]; fa = q_aval[i]; fb = q_bval[i];
        end
      end
    end
  endfunction

  function automatic result_t queue_step(item_t it);
    result_t r;
    int slot;
    logic [QUEUE_ENTRIES-1:0] busy_mask;
    logic aok, bok;
    logic [31:0] aval, bval;
    r = '0;
    pick_oldest(CLASS_INT, it.units[0], r.int_issue, r.int_rob, r.int_first, r.int_second);
    pick_oldest(CLASS_MUL, it.units[1], r.mul_issue, r.mul_rob, r.mul_first, r.mul_second);
    if (it.w_valid) begin
      for (int i = 0; i < QUEUE_ENTRIES; i++) begin
        if (q_busy[i]) begin
          if (!q_aok[i] && q_atag[i] == it.w_tag) begin
            q_aok[i] = 1; q_aval[i] = it.w_val;
          end
          if (!q_bok[i] && q_btag[i] == it.w_tag) begin
            q_bok[i] = 1; q_bval[i] = it.w_val;
          end
        end
      end
    end
    if (it.kind == KIND_INT || it.kind == KIND_MUL) begin
      slot = -1;
      busy_mask = '0;
      for (int i = 0; i < QUEUE_ENTRIES; i++) begin
        if (q_busy[i]) busy_mask[i] = 1;
        else if (slot < 0) slot = i;
      end
      if (slot < 0) begin
        r.rejected = 1;
      end else begin
        for (int i = 0; i < QUEUE_ENTRIES; i++) q_older[i][slot] = 0;
        q_older[slot] = busy_mask;
        aok = it.a_ok; aval = it.a_val;
        bok = it.b_ok; bval = it.b_val;
        if (!aok && it.w_valid && it.w_tag == it.a_tag) begin
          aok = 1; aval = it.w_val;
        end
        if (!bok && it.w_valid && it.w_tag == it.b_tag) begin
          bok = 1; bval = it.w_val;
        end
        q_busy[slot] = 1;
        q_class[slot] = (it.kind == KIND_MUL) ? CLASS_MUL : CLASS_INT;
        q_rob[slot] = it.rob;
        q_atag[slot] = it.a_tag; q_aok[slot] = aok; q_aval[slot] = aval;
        q_btag[slot] = it.b_tag; q_bok[slot] = bok; q_bval[slot] = bval;
      end
    end
    return r;
  endfunction

  function automatic item_t rand_step(int mode);
    item_t it;
    it.kind = 2'($urandom_range(0, 9) < 7 ? $urandom_range(1, 2) : $urandom_range(0, 3));
    it.rob = 5'($urandom);
    it.a_tag = 5'((mode == 0) ? $urandom_range(0, 7) : $urandom);
    it.b_tag = 5'((mode == 0) ? $urandom_range(0, 7) : $urandom);
    it.a_ok = $urandom_range(0, 2) == 0;
    it.b_ok = $urandom_range(0, 2) == 0;
    it.a_val = $urandom;
    it.b_val = $urandom;
    it.w_valid = $urandom_range(0, 3) != 0;
    it.w_tag = 5'((mode == 0) ? $urandom_range(0, 7) : $urandom);
    it.w_val = $urandom;
    it.units = 2'((mode == 2) ? $urandom_range(0, 1) : $urandom);
    return it;
  endfunction

  function automatic item_t make_step(logic [1:0] kind, logic [4:0] rob, logic [4:0] at,
                                      logic aok, logic [31:0] av, logic [4:0] bt,
                                      logic bok, logic [31:0] bv, logic wv,
                                      logic [4:0] wt, logic [31:0] wval, logic [1:0] u);
    item_t it;
    it.kind = kind; it.rob = rob; it.a_tag = at; it.a_ok = aok; it.a_val = av;
    it.b_tag = bt; it.b_ok = bok; it.b_val = bv; it.w_valid = wv; it.w_tag = wt;
    it.w_val = wval; it.units = u;
    return it;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < QUEUE_ENTRIES; i++) begin
      q_busy[i] = 0; q_older[i] = '0; q_class[i] = 0; q_rob[i] = '0;
      q_atag[i] = '0; q_aok[i] = 0; q_aval[i] = '0;
      q_btag[i] = '0; q_bok[i] = 0; q_bval[i] = '0;
    end
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    // directed: extremes, full queue, bypass, already-ready sources, unknown kind
    pending_steps.push_back(make_step(KIND_INT, 5'd31, 5'd0, 1'b1, 32'h7fffffff, 5'd31, 1'b1,
                                      32'h80000000, 1'b0, 5'd0, 32'h0, 2'd0));
    pending_steps.push_back(make_step(KIND_MUL, 5'd0, 5'd3, 1'b0, 32'hffffffff, 5'd3, 1'b0,
                                      32'h0, 1'b1, 5'd3, 32'h80000000, 2'd0));
    pending_steps.push_back(make_step(KIND_INT, 5'd7, 5'd9, 1'b1, 32'h1234, 5'd9, 1'b0, 32'h0,
                                      1'b1, 5'd9, 32'hdeadbeef, 2'd0));
    pending_steps.push_back(make_step(KIND_UNKNOWN, 5'd1, 5'd1, 1'b0, 32'h0, 5'd1, 1'b0,
                                      32'h0, 1'b0, 5'd0, 32'h0, 2'd3));
    pending_steps.push_back(make_step(KIND_NONE, 5'd0, 5'd0, 1'b0, 32'h0, 5'd0, 1'b0, 32'h0,
                                      1'b0, 5'd0, 32'h0, 2'd3));
    for (int i = 0; i < 17; i++)
      pending_steps.push_back(make_step(i[0] ? KIND_MUL : KIND_INT, i[4:0], 5'd20, 1'b0,
                                        32'h0, 5'd21, 1'b1, i, 1'b0, 5'd0, 32'h0, 2'd0));
    pending_steps.push_back(make_step(KIND_INT, 5'd2, 5'd0, 1'b1, 32'h0, 5'd0, 1'b1, 32'h0,
                                      1'b1, 5'd20, 32'h55aa55aa, 2'd0));
    pending_steps.push_back(make_step(KIND_NONE, 5'd0, 5'd0, 1'b0, 32'h0, 5'd0, 1'b0, 32'h0,
                                      1'b1, 5'd20, 32'h1, 2'd3));
    wait (steps_sent == pending_steps.size() + steps_sent && issue_expected.size() == 0);
    for (int i = 0; i < 1425; i++) begin
      if (i == 480) begin
        wait (pending_steps.size() == 0 && issue_expected.size() == 0);
        send_idle_pct = 72; recv_idle_pct = 28;
      end
      if (i == 960) begin
        wait (pending_steps.size() == 0);
        hold_for_drain = 1;
        wait (issue_expected.size() == 0);
        hold_for_drain = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      pending_steps.push_back(rand_step(i % 3));
    end
    wait (pending_steps.size() == 0);
    stim_done = 1;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid) begin
          issue_expected.push_back(queue_step(pending_steps.pop_front()));
          steps_sent++;
        end
        if (pending_steps.size() > 0 && !hold_for_drain &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          item_t nx;
          nx = pending_steps[0];
          s_axis_tvalid <= 1;
          s_axis_tdata <= {2'b00, nx.w_val, nx.w_tag, nx.b_val, nx.b_ok, nx.b_tag,
                           nx.a_val, nx.a_ok, nx.a_tag, nx.rob};
          s_axis_tuser <= {nx.units, nx.w_valid, nx.kind};
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      result_t got;
      got.int_issue = m_axis_tuser[0];
      got.mul_issue = m_axis_tuser[1];
      {got.rejected, got.mul_second, got.mul_first, got.mul_rob,
       got.int_second, got.int_first, got.int_rob} = m_axis_tdata[138:0];
      if (issue_expected.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, got);
        errors++;
      end else begin
        result_t exp_r;
        exp_r = issue_expected.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
          errors++;
        end
        issued_count += exp_r.int_issue + exp_r.mul_issue;
        reject_count += exp_r.rejected;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("issue_queue_wakeup_select verification failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (issue_expected.size() == 0);
    repeat (20) @(posedge clk);
    $display("Steps sent %0d, instructions issued %0d, dispatches rejected %0d",
             steps_sent, issued_count, reject_count);
    if (errors == 0 && issue_expected.size() == 0) begin
      $display("issue_queue_wakeup_select verification clean");
    end else begin
      $display("issue_queue_wakeup_select verification failed");
    end
    $finish;
  end

endmodule
